// ----- sv/cta_pkg.sv -----
// Shared types and constants for the CIGAR to alignment block converter.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cta_pkg;

    localparam int REF_W    = 31;
    localparam int OP_W     = 4;
    localparam int LEN_W    = 28;
    localparam int POS_W    = 32;
    localparam int CNT_W    = 16;
    localparam int KIND_W   = 2;
    localparam int FIFO_DEPTH = 4;

    localparam logic [OP_W-1:0] OP_M  = 4'd0;
    localparam logic [OP_W-1:0] OP_I  = 4'd1;
    localparam logic [OP_W-1:0] OP_D  = 4'd2;
    localparam logic [OP_W-1:0] OP_N  = 4'd3;
    localparam logic [OP_W-1:0] OP_S  = 4'd4;
    localparam logic [OP_W-1:0] OP_H  = 4'd5;
    localparam logic [OP_W-1:0] OP_P  = 4'd6;
    localparam logic [OP_W-1:0] OP_EQ = 4'd7;
    localparam logic [OP_W-1:0] OP_X  = 4'd8;

    localparam logic [KIND_W-1:0] KIND_BLOCK       = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SUMMARY     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SUMMARY_ERR = 2'd2;

    typedef struct packed {
        logic             first_element;
        logic [REF_W-1:0] ref_start;
        logic             reverse_strand;
        logic [OP_W-1:0]  op_kind;
        logic [LEN_W-1:0] op_length;
        logic             last_element;
    } item_t;

    typedef struct packed {
        logic [KIND_W-1:0] result_kind;
        logic [LEN_W-1:0]  block_size;
        logic [POS_W-1:0]  query_start;
        logic [POS_W-1:0]  target_start;
        logic [POS_W-1:0]  query_end;
        logic [POS_W-1:0]  target_end;
        logic [POS_W-1:0]  query_size;
        logic [POS_W-1:0]  match_count;
        logic [POS_W-1:0]  mismatch_count;
        logic [CNT_W-1:0]  block_count;
        logic              no_blocks;
        logic              last;
    } result_t;

    // results produced by one item: first slot, optional second slot
    typedef struct packed {
        logic [1:0] cnt;
        result_t    res_a;
        result_t    res_b;
    } push_t;

endpackage

`default_nettype wire

// ----- sv/cta_core.sv -----
// Record state and per-element update; builds block and summary results.
// Depends on cta_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cta_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          advance,
    input  wire logic          include_hc,
    input  wire cta_pkg::item_t item,
    output cta_pkg::push_t     push
);
    import cta_pkg::*;

    function automatic logic [POS_W-1:0] sat_add(input logic [POS_W-1:0] a,
                                                 input logic [LEN_W-1:0] n);
        logic [POS_W:0] s;
        s = {1'b0, a} + {{(POS_W+1-LEN_W){1'b0}}, n};
        return s[POS_W] ? {POS_W{1'b1}} : s[POS_W-1:0];
    endfunction

    function automatic logic [POS_W-1:0] sat_sub(input logic [POS_W-1:0] a,
                                                 input logic [POS_W-1:0] b);
        return (a > b) ? (a - b) : '0;
    endfunction

    logic [POS_W-1:0] tpos_reg, tpos_next, qpos_reg, qpos_next;
    logic [POS_W-1:0] qtot_reg, qtot_next, mtot_reg, mtot_next, xtot_reg, xtot_next;
    logic [CNT_W-1:0] blocks_reg, blocks_next;
    logic [POS_W-1:0] fqs_reg, fqs_next, fts_reg, fts_next;
    logic [POS_W-1:0] lqe_reg, lqe_next, lte_reg, lte_next;
    logic             rev_reg, rev_next, bad_reg, bad_next;

    logic [POS_W-1:0] tpos_e, qpos_e, qtot_e, mtot_e, xtot_e;
    logic [CNT_W-1:0] blocks_e;
    logic [POS_W-1:0] fqs_e, fts_e, lqe_e, lte_e;
    logic             rev_e, bad_e;
    logic             is_blk;
    logic [POS_W-1:0] qs, qe, ts, te;
    result_t          blk_res, sum_res;

    always_comb
    begin
        if (item.first_element)
        begin
            tpos_e   = {1'b0, item.ref_start};
            qpos_e   = '0;
            qtot_e   = '0;
            mtot_e   = '0;
            xtot_e   = '0;
            blocks_e = '0;
            fqs_e    = '0;
            fts_e    = '0;
            lqe_e    = '0;
            lte_e    = '0;
            rev_e    = item.reverse_strand;
            bad_e    = 1'b0;
        end
        else
        begin
            tpos_e   = tpos_reg;
            qpos_e   = qpos_reg;
            qtot_e   = qtot_reg;
            mtot_e   = mtot_reg;
            xtot_e   = xtot_reg;
            blocks_e = blocks_reg;
            fqs_e    = fqs_reg;
            fts_e    = fts_reg;
            lqe_e    = lqe_reg;
            lte_e    = lte_reg;
            rev_e    = rev_reg;
            bad_e    = bad_reg;
        end

        tpos_next   = tpos_e;
        qpos_next   = qpos_e;
        qtot_next   = qtot_e;
        mtot_next   = mtot_e;
        xtot_next   = xtot_e;
        blocks_next = blocks_e;
        fqs_next    = fqs_e;
        fts_next    = fts_e;
        lqe_next    = lqe_e;
        lte_next    = lte_e;
        rev_next    = rev_e;
        bad_next    = bad_e;
        is_blk      = 1'b0;

        case (item.op_kind)
            OP_M, OP_EQ, OP_X:
            begin
                is_blk = 1'b1;
                if (blocks_e == '0)
                begin
                    fqs_next = qpos_e;
                    fts_next = tpos_e;
                end
                tpos_next = sat_add(tpos_e, item.op_length);
                qpos_next = sat_add(qpos_e, item.op_length);
                lqe_next  = qpos_next;
                lte_next  = tpos_next;
                qtot_next = sat_add(qtot_e, item.op_length);
                if (blocks_e != {CNT_W{1'b1}})
                    blocks_next = blocks_e + CNT_W'(1);
                if (item.op_kind == OP_X)
                    xtot_next = sat_add(xtot_e, item.op_length);
                else
                    mtot_next = sat_add(mtot_e, item.op_length);
            end
            OP_I, OP_S:
            begin
                qpos_next = sat_add(qpos_e, item.op_length);
                qtot_next = sat_add(qtot_e, item.op_length);
            end
            OP_D, OP_N:
            begin
                tpos_next = sat_add(tpos_e, item.op_length);
            end
            OP_H:
            begin
                if (include_hc)
                begin
                    qpos_next = sat_add(qpos_e, item.op_length);
                    qtot_next = sat_add(qtot_e, item.op_length);
                end
            end
            OP_P:
            begin
            end
            default:
            begin
                bad_next = 1'b1;
            end
        endcase

        qs = '0;
        qe = '0;
        ts = '0;
        te = '0;
        if (blocks_next != '0)
        begin
            ts = fts_next;
            te = lte_next;
            if (rev_next)
            begin
                qs = sat_sub(qtot_next, lqe_next);
                qe = sat_sub(qtot_next, fqs_next);
            end
            else
            begin
                qs = fqs_next;
                qe = lqe_next;
            end
        end

        blk_res              = '0;
        blk_res.result_kind  = KIND_BLOCK;
        blk_res.block_size   = item.op_length;
        blk_res.query_start  = qpos_e;
        blk_res.target_start = tpos_e;

        sum_res                = '0;
        sum_res.result_kind    = bad_next ? KIND_SUMMARY_ERR : KIND_SUMMARY;
        sum_res.query_start    = qs;
        sum_res.target_start   = ts;
        sum_res.query_end      = qe;
        sum_res.target_end     = te;
        sum_res.query_size     = qtot_next;
        sum_res.match_count    = mtot_next;
        sum_res.mismatch_count = xtot_next;
        sum_res.block_count    = blocks_next;
        sum_res.no_blocks      = (blocks_next == '0);
        sum_res.last           = 1'b1;

        push.cnt   = {1'b0, is_blk} + {1'b0, item.last_element};
        push.res_a = is_blk ? blk_res : sum_res;
        push.res_b = sum_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tpos_reg   <= '0;
            qpos_reg   <= '0;
            qtot_reg   <= '0;
            mtot_reg   <= '0;
            xtot_reg   <= '0;
            blocks_reg <= '0;
            fqs_reg    <= '0;
            fts_reg    <= '0;
            lqe_reg    <= '0;
            lte_reg    <= '0;
            rev_reg    <= 1'b0;
            bad_reg    <= 1'b0;
        end
        else if (advance)
        begin
            tpos_reg   <= tpos_next;
            qpos_reg   <= qpos_next;
            qtot_reg   <= qtot_next;
            mtot_reg   <= mtot_next;
            xtot_reg   <= xtot_next;
            blocks_reg <= blocks_next;
            fqs_reg    <= fqs_next;
            fts_reg    <= fts_next;
            lqe_reg    <= lqe_next;
            lte_reg    <= lte_next;
            rev_reg    <= rev_next;
            bad_reg    <= bad_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/cta_fifo.sv -----
// Result queue: takes up to two results per cycle, delivers one per cycle while pop is high.
// Depends on cta_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cta_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_en,
    input  wire cta_pkg::push_t    push,
    input  wire logic              pop,
    output cta_pkg::result_t       head,
    output logic                   not_empty,
    output logic [$clog2(cta_pkg::FIFO_DEPTH):0] count
);
    import cta_pkg::*;

    localparam int PW = $clog2(FIFO_DEPTH);

    result_t         mem [FIFO_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [PW:0]     count_reg, count_next;
    logic [1:0]      n_push;
    logic            do_pop;

    assign not_empty = (count_reg != '0);
    assign head      = mem[rd_ptr_reg];
    assign count     = count_reg;
    assign do_pop    = pop && not_empty;
    assign n_push    = push_en ? push.cnt : 2'd0;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(n_push);
        rd_ptr_next = rd_ptr_reg + PW'(do_pop);
        count_next  = count_reg + (PW+1)'(n_push) - (PW+1)'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
            mem[wr_ptr_reg] <= push.res_a;
        if (n_push == 2'd2)
            mem[wr_ptr_reg + PW'(1)] <= push.res_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ----- sv/cigar_to_alignment_blocks.sv -----
// CIGAR element stream to aligned blocks and record summaries.
// An accepted item is registered, then its results are written to the result queue.
// Throughput: one item per cycle while in_stall is low; an item giving both a block
// and a summary pushes two results into a 4-entry result queue that drains one at a time.
// Reset clears record state, the hard-clip register and the queue.
// Depends on cta_pkg, cta_core, cta_fifo.
`timescale 1ns / 1ps
`default_nettype none

module cigar_to_alignment_blocks (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_write,
    input  wire logic                           cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic                           first_element,
    input  wire logic [cta_pkg::REF_W-1:0]      ref_start,
    input  wire logic                           reverse_strand,
    input  wire logic [cta_pkg::OP_W-1:0]       op_kind,
    input  wire logic [cta_pkg::LEN_W-1:0]      op_length,
    input  wire logic                           last_element,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [cta_pkg::KIND_W-1:0]          result_kind,
    output logic [cta_pkg::LEN_W-1:0]           block_size,
    output logic [cta_pkg::POS_W-1:0]           query_start,
    output logic [cta_pkg::POS_W-1:0]           target_start,
    output logic [cta_pkg::POS_W-1:0]           query_end,
    output logic [cta_pkg::POS_W-1:0]           target_end,
    output logic [cta_pkg::POS_W-1:0]           query_size,
    output logic [cta_pkg::POS_W-1:0]           match_count,
    output logic [cta_pkg::POS_W-1:0]           mismatch_count,
    output logic [cta_pkg::CNT_W-1:0]           block_count,
    output logic                                no_blocks,
    output logic                                last
);
    import cta_pkg::*;

    localparam int CW = $clog2(FIFO_DEPTH) + 1;

    logic          hc_reg;
    logic          item_valid_reg, item_valid_next;
    item_t         item_reg;
    logic          accept, advance;
    push_t         push;
    result_t       head;
    logic [CW-1:0] q_count;
    logic [CW:0]   q_need;

    assign q_need   = {1'b0, q_count} + (CW+1)'(push.cnt);
    assign advance  = item_valid_reg && (q_need <= (CW+1)'(FIFO_DEPTH));
    assign in_stall = item_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (accept)
            item_valid_next = 1'b1;
        else if (advance)
            item_valid_next = 1'b0;
        else
            item_valid_next = item_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hc_reg         <= 1'b0;
            item_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
                hc_reg <= cfg_data;
            item_valid_reg <= item_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.first_element  <= first_element;
            item_reg.ref_start      <= ref_start;
            item_reg.reverse_strand <= reverse_strand;
            item_reg.op_kind        <= op_kind;
            item_reg.op_length      <= op_length;
            item_reg.last_element   <= last_element;
        end
    end

    cta_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .include_hc (hc_reg),
        .item       (item_reg),
        .push       (push)
    );

    cta_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_en   (advance),
        .push      (push),
        .pop       (!out_stall),
        .head      (head),
        .not_empty (out_valid),
        .count     (q_count)
    );

    assign result_kind    = head.result_kind;
    assign block_size     = head.block_size;
    assign query_start    = head.query_start;
    assign target_start   = head.target_start;
    assign query_end      = head.query_end;
    assign target_end     = head.target_end;
    assign query_size     = head.query_size;
    assign match_count    = head.match_count;
    assign mismatch_count = head.mismatch_count;
    assign block_count    = head.block_count;
    assign no_blocks      = head.no_blocks;
    assign last           = head.last;

endmodule

`default_nettype wire

// ----- sim/cigar_to_alignment_blocks_tb.sv -----
// Testbench for cigar_to_alignment_blocks: directed and random CIGAR records, predicted
// block and summary items checked against the output stream. Depends on cta_pkg and the RTL.
`timescale 1ns / 1ps

module cigar_to_alignment_blocks_tb;

    import cta_pkg::*;

    localparam logic [OP_W-1:0] OP_BAD_LOW  = 4'd9;
    localparam logic [OP_W-1:0] OP_BAD_HIGH = 4'd15;
    localparam logic [LEN_W-1:0] LEN_MAX    = '1;
    localparam logic [REF_W-1:0] REF_MAX    = '1;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int PHASE_ITEMS    = 320;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_write = 1'b0;
    logic cfg_data = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic out_valid;
    logic out_stall = 1'b0;
    item_t presented = '0;

    logic [KIND_W-1:0] result_kind;
    logic [LEN_W-1:0]  block_size;
    logic [POS_W-1:0]  query_start, target_start, query_end, target_end;
    logic [POS_W-1:0]  query_size, match_count, mismatch_count;
    logic [CNT_W-1:0]  block_count;
    logic              no_blocks, last;

    item_t   cigar_elements_to_send[$];
    result_t expected_alignment_items[$];
    result_t awaited;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int mismatches = 0;
    int quiet_cycles = 0;

    // predicted record state
    logic [POS_W-1:0] track_target = '0, track_query = '0, query_len_total = '0;
    logic [POS_W-1:0] match_sum = '0, mismatch_sum = '0;
    logic [CNT_W-1:0] block_tally = '0;
    logic [POS_W-1:0] span_q_first = '0, span_t_first = '0, span_q_end = '0, span_t_end = '0;
    logic minus_strand = 1'b0, saw_bad_op = 1'b0, hard_clip_on = 1'b0;

    cigar_to_alignment_blocks dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .first_element  (presented.first_element),
        .ref_start      (presented.ref_start),
        .reverse_strand (presented.reverse_strand),
        .op_kind        (presented.op_kind),
        .op_length      (presented.op_length),
        .last_element   (presented.last_element),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .result_kind    (result_kind),
        .block_size     (block_size),
        .query_start    (query_start),
        .target_start   (target_start),
        .query_end      (query_end),
        .target_end     (target_end),
        .query_size     (query_size),
        .match_count    (match_count),
        .mismatch_count (mismatch_count),
        .block_count    (block_count),
        .no_blocks      (no_blocks),
        .last           (last)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    function automatic logic [POS_W-1:0] clamp_add(input logic [POS_W-1:0] a,
                                                  input logic [POS_W-1:0] b);
        logic [POS_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[POS_W] ? '1 : s[POS_W-1:0];
    endfunction

    function automatic logic [POS_W-1:0] floor_sub(input logic [POS_W-1:0] a,
                                                  input logic [POS_W-1:0] b);
        return (a > b) ? a - b : '0;
    endfunction

    function automatic item_t make_element(input logic first, input logic [REF_W-1:0] rstart,
                                           input logic rev, input logic [OP_W-1:0] op,
                                           input logic [LEN_W-1:0] len, input logic lastel);
        item_t el;
        el.first_element  = first;
        el.ref_start      = rstart;
        el.reverse_strand = rev;
        el.op_kind        = op;
        el.op_length      = len;
        el.last_element   = lastel;
        return el;
    endfunction

    task automatic predict_alignment(input item_t el);
        result_t r;
        logic [POS_W-1:0] len, qs, qe, ts, te, mirrored;
        len = {{(POS_W-LEN_W){1'b0}}, el.op_length};
        if (el.first_element)
        begin
            track_target    = {1'b0, el.ref_start};
            track_query     = '0;
            query_len_total = '0;
            match_sum       = '0;
            mismatch_sum    = '0;
            block_tally     = '0;
            span_q_first    = '0;
            span_t_first    = '0;
            span_q_end      = '0;
            span_t_end      = '0;
            minus_strand    = el.reverse_strand;
            saw_bad_op      = 1'b0;
        end
        case (el.op_kind)
            OP_M, OP_EQ, OP_X:
            begin
                r = '0;
                r.result_kind  = KIND_BLOCK;
                r.block_size   = el.op_length;
                r.query_start  = track_query;
                r.target_start = track_target;
                expected_alignment_items.push_back(r);
                if (block_tally == 0)
                begin
                    span_q_first = track_query;
                    span_t_first = track_target;
                end
                span_q_end = clamp_add(track_query, len);
                span_t_end = clamp_add(track_target, len);
                if (block_tally != '1)
                    block_tally = block_tally + CNT_W'(1);
                track_target    = clamp_add(track_target, len);
                track_query     = clamp_add(track_query, len);
                query_len_total = clamp_add(query_len_total, len);
                if (el.op_kind == OP_X)
                    mismatch_sum = clamp_add(mismatch_sum, len);
                else
                    match_sum = clamp_add(match_sum, len);
            end
            OP_I, OP_S:
            begin
                track_query     = clamp_add(track_query, len);
                query_len_total = clamp_add(query_len_total, len);
            end
            OP_D, OP_N:
                track_target = clamp_add(track_target, len);
            OP_H:
            begin
                if (hard_clip_on)
                begin
                    track_query     = clamp_add(track_query, len);
                    query_len_total = clamp_add(query_len_total, len);
                end
            end
            OP_P:
                ;
            default:
                saw_bad_op = 1'b1;
        endcase
        if (el.last_element)
        begin
            qs = '0;
            qe = '0;
            ts = '0;
            te = '0;
            if (block_tally != 0)
            begin
                qs = span_q_first;
                qe = span_q_end;
                ts = span_t_first;
                te = span_t_end;
                if (minus_strand)
                begin
                    mirrored = floor_sub(query_len_total, qe);
                    qe = floor_sub(query_len_total, qs);
                    qs = mirrored;
                end
            end
            r = '0;
            r.result_kind    = saw_bad_op ? KIND_SUMMARY_ERR : KIND_SUMMARY;
            r.query_start    = qs;
            r.target_start   = ts;
            r.query_end      = qe;
            r.target_end     = te;
            r.query_size     = query_len_total;
            r.match_count    = match_sum;
            r.mismatch_count = mismatch_sum;
            r.block_count    = block_tally;
            r.no_blocks      = (block_tally == 0);
            r.last           = 1'b1;
            expected_alignment_items.push_back(r);
        end
    endtask

    task automatic check_field(input string name, input logic [POS_W-1:0] want,
                               input logic [POS_W-1:0] got);
        if (want !== got)
        begin
            if (mismatches < 100)
                $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // driver
    always @(posedge clk)
    begin
        if (rst_n && (!in_valid || !in_stall))
        begin
            if (cigar_elements_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                presented <= cigar_elements_to_send.pop_front();
                in_valid  <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    // predictor runs on accepted input items and register writes
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                predict_alignment(presented);
            if (cfg_write)
                hard_clip_on = cfg_data;
        end
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_alignment_items.size() == 0)
                begin
                    if (mismatches < 100)
                        $display("%0t: unexpected item, expected none, got kind %0d",
                                 $time, result_kind);
                    mismatches++;
                end
                else
                begin
                    awaited = expected_alignment_items.pop_front();
                    check_field("result_kind", POS_W'(awaited.result_kind),
                                POS_W'(result_kind));
                    check_field("block_size", POS_W'(awaited.block_size),
                                POS_W'(block_size));
                    check_field("query_start", awaited.query_start, query_start);
                    check_field("target_start", awaited.target_start, target_start);
                    check_field("query_end", awaited.query_end, query_end);
                    check_field("target_end", awaited.target_end, target_end);
                    check_field("query_size", awaited.query_size, query_size);
                    check_field("match_count", awaited.match_count, match_count);
                    check_field("mismatch_count", awaited.mismatch_count, mismatch_count);
                    check_field("block_count", POS_W'(awaited.block_count),
                                POS_W'(block_count));
                    check_field("no_blocks", POS_W'(awaited.no_blocks), POS_W'(no_blocks));
                    check_field("last", POS_W'(awaited.last), POS_W'(last));
                end
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("cigar_to_alignment_blocks regression: fail");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic wait_until_drained();
        do
            @(negedge clk);
        while (cigar_elements_to_send.size() != 0 || in_valid
               || expected_alignment_items.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_random_records(input int target_items);
        item_t el;
        int queued, rec_len, len_style, roll, k;
        queued = 0;
        while (queued < target_items)
        begin
            len_style = $urandom_range(99);
            rec_len = (len_style >= 95) ? $urandom_range(12, 24) : $urandom_range(1, 10);
            for (k = 0; k < rec_len; k++)
            begin
                el.first_element = (k == 0) ? ($urandom_range(99) >= 8)
                                            : ($urandom_range(99) < 2);
                el.last_element  = (k == rec_len - 1) ? 1'b1 : ($urandom_range(99) < 2);
                el.reverse_strand = 1'($urandom_range(1));
                roll = $urandom_range(99);
                if (roll < 60)
                    el.ref_start = REF_W'($urandom_range(0, 100000));
                else if (roll < 90)
                    el.ref_start = REF_W'($urandom);
                else
                    el.ref_start = $urandom_range(1) ? REF_MAX : '0;
                roll = $urandom_range(99);
                if (roll < 30)
                    el.op_kind = OP_M;
                else if (roll < 40)
                    el.op_kind = OP_EQ;
                else if (roll < 50)
                    el.op_kind = OP_X;
                else if (roll < 60)
                    el.op_kind = OP_I;
                else if (roll < 68)
                    el.op_kind = OP_D;
                else if (roll < 73)
                    el.op_kind = OP_N;
                else if (roll < 81)
                    el.op_kind = OP_S;
                else if (roll < 89)
                    el.op_kind = OP_H;
                else if (roll < 94)
                    el.op_kind = OP_P;
                else
                    el.op_kind = OP_W'($urandom_range(OP_BAD_LOW, OP_BAD_HIGH));
                if (len_style >= 95)
                    el.op_length = ($urandom_range(99) < 80) ? LEN_MAX : LEN_W'($urandom);
                else if (len_style >= 80)
                    el.op_length = LEN_W'($urandom);
                else
                    el.op_length = LEN_W'($urandom_range(0, 300));
                cigar_elements_to_send.push_back(el);
                queued++;
            end
        end
    endtask

    // register is written while idle; the record left open by the previous phase is
    // closed with a hard clip so the new setting applies mid-record
    task automatic run_random_phase(input logic hard_clip, input int idle_pct,
                                    input int stall_rate);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= hard_clip;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
        send_idle_pct = idle_pct;
        stall_pct     = stall_rate;
        cigar_elements_to_send.push_back(make_element(0, 0, 0, OP_H, 7, 1));
        queue_random_records(PHASE_ITEMS);
        cigar_elements_to_send.push_back(make_element(1,
                                                      REF_W'($urandom_range(0, 5000)),
                                                      1'($urandom_range(1)), OP_M, 10, 0));
    endtask

    initial
    begin
        int i;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // elements before any record start continue from reset state
        cigar_elements_to_send.push_back(make_element(0, 0, 0, OP_M, 5, 0));
        cigar_elements_to_send.push_back(make_element(0, 0, 0, OP_I, 3, 1));
        // minus strand record with every valid op
        cigar_elements_to_send.push_back(make_element(1, 1000, 1, OP_S, 10, 0));
        cigar_elements_to_send.push_back(make_element(0, 0, 1, OP_M, 50, 0));
        cigar_elements_to_send.push_back(make_element(0, 0, 0, OP_D, 4, 0));
        cigar_elements_to_send.push_back(make_element(0, 0, 0, OP_EQ, 20, 0));
        cigar_elements_to_send.push_back(make_element(0, 0, 0, OP_I, 2, 0));
        cigar_elements_to_send.push_back(make_element(0, 0, 0, OP_X, 15, 0));
        cigar_elements_to_send.push_back(make_element(0, 0, 0, OP_H, 9, 0));
        cigar_elements_to_send.push_back(make_element(0, 0, 0, OP_P, 4, 0));
        cigar_elements_to_send.push_back(make_element(0, 0, 0, OP_N, 100, 0));
        cigar_elements_to_send.push_back(make_element(0, 0, 0, OP_S, 5, 1));
        // invalid op codes around a zero-length block
        cigar_elements_to_send.push_back(make_element(1, 0, 0, OP_BAD_LOW, LEN_MAX, 0));
        cigar_elements_to_send.push_back(make_element(0, 0, 0, OP_M, 0, 0));
        cigar_elements_to_send.push_back(make_element(0, 0, 0, OP_BAD_HIGH, 0, 1));
        // single element record with no block
        cigar_elements_to_send.push_back(make_element(1, REF_MAX, 1, OP_H, LEN_MAX, 1));
        // target position and block end saturation
        cigar_elements_to_send.push_back(make_element(1, REF_MAX, 0, OP_N, LEN_MAX, 0));
        for (i = 0; i < 7; i++)
            cigar_elements_to_send.push_back(make_element(0, 0, 0, OP_N, LEN_MAX, 0));
        cigar_elements_to_send.push_back(make_element(0, 0, 0, OP_M, LEN_MAX, 1));
        wait_until_drained();

        run_random_phase(1'b1, 0, 0);
        wait_until_drained();

        run_random_phase(1'b0, 55, 0);
        wait_until_drained();
        run_random_phase(1'b1, 0, 55);
        wait_until_drained();
        run_random_phase(1'b0, 12, 12);
        wait_until_drained();
        run_random_phase(1'b1, 0, 0);
        cigar_elements_to_send.push_back(make_element(0, 0, 0, OP_H, 3, 1));
        wait_until_drained();

        if (mismatches == 0)
            $display("cigar_to_alignment_blocks regression: pass");
        else
            $display("cigar_to_alignment_blocks regression: fail");
        $finish;
    end

endmodule
